FILE: hw/rtl/swbs_pkg.sv
package swbs_pkg;

    localparam int HALF_W    = 56;
    localparam int KEY_CHARS = 14;
    localparam int KEY_W     = 2 * HALF_W;
    localparam int SLOT_W    = 7;
    localparam int COUNT_W   = 8;
    localparam int POS_W     = 7;

    localparam int DEF_TABLE_DEPTH = 128;
    localparam int DEF_WORD_CHARS  = 14;

    // operation codes carried on the func field
    localparam logic FUNC_WRITE  = 1'b0;
    localparam logic FUNC_LOOKUP = 1'b1;

endpackage

FILE: hw/rtl/swbs_ram.sv
module swbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/sorted_word_table_binary_search.sv
// Sorted word table with binary search.
//
// Input channel (i_in_valid / o_in_stall) carries one item per transfer:
//   func = write  : stores {key_high, key_low} at table index slot, no result.
//   func = lookup : binary search over entries 0 .. entry_count-1, which the
//                   user keeps in ascending order; one result (found, position).
// Output channel (o_out_valid / i_out_stall) carries the lookup results.
// Config channel (i_cfg_valid / o_cfg_ready) writes entry_count; always ready.
//
// Sequencing: a write is stored as it is accepted and the block stays idle. A
// lookup runs search steps of one table RAM read (S_SEARCH), then the compare
// (S_CMP), and ends in S_DONE; o_in_stall stays high from the accepting edge
// until it returns to idle, so the next item waits for the search to finish.
// The single table RAM read port sets this.
// A new item is taken while an earlier result still waits in the output
// register; a finished search waits in its last state until that slot frees.
// Reset (synchronous, active low) clears control state and entry_count; the
// table contents are undefined until written. A stalled receiver holds the
// result steady and backs up into o_in_stall once the next search finishes.
module sorted_word_table_binary_search #(
    parameter int TABLE_DEPTH = swbs_pkg::DEF_TABLE_DEPTH,
    parameter int WORD_CHARS  = swbs_pkg::DEF_WORD_CHARS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [swbs_pkg::SLOT_W-1:0]   i_slot,
    input  logic [swbs_pkg::HALF_W-1:0]   i_key_high,
    input  logic [swbs_pkg::HALF_W-1:0]   i_key_low,
    // result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic [swbs_pkg::POS_W-1:0]    o_position,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swbs_pkg::COUNT_W-1:0]  i_cfg_data
);
    import swbs_pkg::*;

    // only the leading characters that fit both the word and the ports are kept
    localparam int KEEP_CHARS = (WORD_CHARS < KEY_CHARS) ? WORD_CHARS : KEY_CHARS;
    localparam int MEM_W      = 8 * KEEP_CHARS;
    localparam int ADDR_W     = $clog2(TABLE_DEPTH);
    // bounds run 0 .. TABLE_DEPTH
    localparam int BW         = $clog2(TABLE_DEPTH + 1);
    localparam int CW         = (BW > COUNT_W) ? BW : COUNT_W;
    localparam int SW         = (BW > SLOT_W) ? BW : SLOT_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_CMP,
        S_DONE
    } t_state;

    t_state             r_state;
    logic [COUNT_W-1:0] r_entry_count;
    logic [MEM_W-1:0]   r_key;
    // search window is [r_lo, r_hp1); r_hp1 is the high bound plus one
    logic [BW-1:0]      r_lo;
    logic [BW-1:0]      r_hp1;
    logic [ADDR_W-1:0]  r_mid;
    logic               r_hit;
    logic               r_out_valid;
    logic               r_found;
    logic [POS_W-1:0]   r_position;

    logic [KEY_W-1:0]   key_full;
    logic [MEM_W-1:0]   key_kept;
    logic [CW-1:0]      cnt_ext;
    logic [BW-1:0]      cnt_sat;
    logic               in_xfer;
    logic               wr_en;
    logic [BW:0]        mid_sum;
    logic [ADDR_W-1:0]  n_mid;
    logic [MEM_W-1:0]   rd_word;
    logic               out_free;

    assign key_full = {i_key_high, i_key_low};
    assign key_kept = key_full[KEY_W-1 -: MEM_W];

    // entry_count above the table depth searches the whole table
    assign cnt_ext = CW'(r_entry_count);
    assign cnt_sat = (cnt_ext > CW'(TABLE_DEPTH)) ? BW'(TABLE_DEPTH) : BW'(cnt_ext);

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;
    assign wr_en      = in_xfer && (i_func == FUNC_WRITE)
                        && (SW'(i_slot) < SW'(TABLE_DEPTH));

    // floor((lo + hi) / 2) with hi = hp1 - 1; only used while lo < hp1
    assign mid_sum = (BW + 1)'(r_lo) + (BW + 1)'(r_hp1) - (BW + 1)'(1);
    assign n_mid   = ADDR_W'(mid_sum >> 1);

    assign out_free = !r_out_valid || !i_out_stall;

    swbs_ram #(
        .WIDTH (MEM_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (ADDR_W'(i_slot)),
        .i_wdata (key_kept),
        .i_re    (r_state == S_SEARCH),
        .i_raddr (n_mid),
        .o_rdata (rd_word)
    );

    // configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_entry_count <= i_cfg_data;
        end
    end

    // search sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_lo        <= '0;
            r_hp1       <= '0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // S_DONE reloads the result register itself when it frees
            if (r_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_func == FUNC_LOOKUP)) begin
                        r_key   <= key_kept;
                        r_lo    <= '0;
                        r_hp1   <= cnt_sat;
                        r_hit   <= 1'b0;
                        r_state <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    if (r_lo < r_hp1) begin
                        r_mid   <= n_mid;
                        r_state <= S_CMP;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_CMP: begin
                    if (rd_word < r_key) begin
                        r_lo    <= BW'(r_mid) + BW'(1);
                        r_state <= S_SEARCH;
                    end else if (rd_word > r_key) begin
                        r_hp1   <= BW'(r_mid);
                        r_state <= S_SEARCH;
                    end else begin
                        r_hit   <= 1'b1;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_found     <= r_hit;
                        r_position  <= r_hit ? POS_W'(r_mid) : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_position  = r_position;

    // the compared entry lies inside the live window
    a_mid_in_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((BW'(r_mid) >= r_lo) && (BW'(r_mid) < r_hp1)))
        else $error("search midpoint outside window");

    // the window stays ordered and never grows past the table depth
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> ((r_lo <= r_hp1) && (r_hp1 <= BW'(TABLE_DEPTH))))
        else $error("search window out of range");

    // table writes only happen between searches
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> (r_state == S_IDLE))
        else $error("table write during search");

    // a miss reports position zero
    a_miss_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_position == '0))
        else $error("miss with nonzero position");

    // a pending result is not overwritten by the next search
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_found)
            && $stable(o_position)))
        else $error("pending result overwritten");

endmodule

FILE: dv/word_search_tb_pkg.sv
`timescale 1ns / 100ps

package word_search_tb_pkg;
    import swbs_pkg::*;

    localparam int DEPTH = DEF_TABLE_DEPTH;

    typedef struct packed {
        logic                func;
        logic [SLOT_W-1:0]   slot;
        logic [HALF_W-1:0]   key_high;
        logic [HALF_W-1:0]   key_low;
    } t_word_item;

    typedef struct packed {
        logic                found;
        logic [POS_W-1:0]    position;
    } t_search_result;

    // Mirrors the word table and the entry count, predicts each lookup answer.
    class word_search_scoreboard;
        logic [KEY_W-1:0]    word_store [DEPTH];
        logic [COUNT_W-1:0]  entry_count;
        t_search_result      expected_q [$];
        int unsigned         mismatches;

        function new();
            entry_count = '0;
            mismatches  = 0;
            foreach (word_store[i]) word_store[i] = '0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        // Floor midpoint; count saturates at the table depth.
        function t_search_result search(logic [KEY_W-1:0] key);
            t_search_result res;
            int lo, hi, mid;
            res = '0;
            lo  = 0;
            hi  = (int'(entry_count) > DEPTH) ? DEPTH - 1 : int'(entry_count) - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (word_store[mid] < key) begin
                    lo = mid + 1;
                end else if (word_store[mid] > key) begin
                    hi = mid - 1;
                end else begin
                    res.found    = 1'b1;
                    res.position = POS_W'(mid);
                    break;
                end
            end
            return res;
        endfunction

        function void note_item(t_word_item item);
            if (item.func == FUNC_WRITE) begin
                word_store[item.slot] = {item.key_high, item.key_low};
            end else begin
                expected_q.push_back(search({item.key_high, item.key_low}));
            end
        endfunction

        function void check_result(t_search_result got);
            t_search_result want;
            if (expected_q.size() == 0) begin
                $error("result with no lookup pending: found %0d position %0d",
                       got.found, got.position);
                mismatches++;
                return;
            end
            want = expected_q.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                mismatches++;
            end
            if (got.position !== want.position) begin
                $error("position: expected %0d, actual %0d", want.position, got.position);
                mismatches++;
            end
        endfunction
    endclass

endpackage

FILE: dv/sorted_word_table_binary_search_tb.sv
`timescale 1ns / 100ps

module sorted_word_table_binary_search_tb;
    import swbs_pkg::*;
    import word_search_tb_pkg::*;

    localparam int RANDOM_ITEMS = 1400;
    localparam int HOLD_CYCLES  = 500;      // long receiver hold-off
    localparam int DRAIN_CYCLES = 32;       // longer than the worst lookup
    localparam int CYCLE_LIMIT  = 800000;

    // Directed words: zero, a word with bytes after a zero byte, its
    // neighbor differing only in the low half, and the all-ones word.
    localparam logic [KEY_W-1:0] W_ZERO   = '0;
    localparam logic [KEY_W-1:0] W_GAP_A  = {56'h41004200000000, 56'h00000000000000};
    localparam logic [KEY_W-1:0] W_GAP_B  = {56'h41004200000000, 56'h00000000000001};
    localparam logic [KEY_W-1:0] W_ONES   = '1;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    logic                 i_func      = FUNC_WRITE;
    logic [SLOT_W-1:0]    i_slot      = '0;
    logic [HALF_W-1:0]    i_key_high  = '0;
    logic [HALF_W-1:0]    i_key_low   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic                 o_found;
    logic [POS_W-1:0]     o_position;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [COUNT_W-1:0]   i_cfg_data  = '0;

    word_search_scoreboard search_board;

    int unsigned          items_sent   = 0;
    int unsigned          results_done = 0;
    int unsigned          holds_done   = 0;
    int unsigned          cycle_count  = 0;
    bit                   in_lookup_run = 1'b0;   // sender is streaming lookups
    bit                   tight_flow    = 1'b0;   // mostly back-to-back transfers
    logic [HALF_W-1:0]    prefixes [3];           // shared high halves per phase

    sorted_word_table_binary_search uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_slot      (i_slot),
        .i_key_high  (i_key_high),
        .i_key_low   (i_key_low),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_position  (o_position),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Run guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results pending",
                   cycle_count, search_board.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Per-transfer wait; tight phases keep long runs with no gaps at all.
    function automatic int unsigned flow_gap();
        if (tight_flow) return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        return $urandom_range(0, 13);
    endfunction

    // Random word: often a shared high half (so the low half decides the
    // order), often cut to a real word length with zero padding.
    function automatic logic [KEY_W-1:0] random_word();
        logic [127:0]      raw;
        logic [KEY_W-1:0]  w;
        int unsigned       len;
        raw = {$urandom, $urandom, $urandom, $urandom};
        w   = raw[KEY_W-1:0];
        if ($urandom_range(0, 1) == 1) w[KEY_W-1 -: HALF_W] = prefixes[$urandom_range(0, 2)];
        if ($urandom_range(0, 1) == 1) begin
            len = $urandom_range(1, KEY_CHARS);
            w   = w & ~({KEY_W{1'b1}} >> (8 * len));
        end
        return w;
    endfunction

    // Lookup key: mostly a word in the searched range, else a near miss,
    // a one-bit change or a fresh word.
    function automatic logic [KEY_W-1:0] probe_key(int unsigned n);
        logic [KEY_W-1:0]  k;
        int unsigned       pick;
        if (n == 0) return random_word();
        k    = search_board.word_store[$urandom_range(0, n - 1)];
        pick = $urandom_range(0, 9);
        if (pick < 6) return k;
        if (pick == 6) return k + 1'b1;
        if (pick == 7) return k - 1'b1;
        if (pick == 8) begin
            k[$urandom_range(0, KEY_W - 1)] ^= 1'b1;
            return k;
        end
        return random_word();
    endfunction

    // One input transfer. Valid stays high after a transfer so that a
    // zero gap gives back-to-back items; it is lowered only for a gap.
    task automatic send_item(logic func, logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] word);
        int unsigned  gap;
        t_word_item   item;
        gap = flow_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item.func     = func;
        item.slot     = slot;
        item.key_high = word[KEY_W-1 -: HALF_W];
        item.key_low  = word[HALF_W-1:0];
        i_in_valid <= 1'b1;
        i_func     <= item.func;
        i_slot     <= item.slot;
        i_key_high <= item.key_high;
        i_key_low  <= item.key_low;
        do @(posedge i_clk); while (o_in_stall);
        search_board.note_item(item);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Sender pause: every expected result in, then let the block go quiet.
    task automatic settle();
        in_lookup_run = 1'b0;
        i_in_valid <= 1'b0;
        while (search_board.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_count(logic [COUNT_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        search_board.entry_count = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Writes slots 0..n-1 with an ascending list, a few duplicates mixed in.
    task automatic load_sorted(int unsigned n);
        logic [KEY_W-1:0]  words [DEPTH];
        logic [KEY_W-1:0]  held;
        int                j;
        for (int i = 0; i < int'(n); i++) begin
            words[i] = (i > 0 && $urandom_range(0, 9) == 0) ? words[i - 1] : random_word();
        end
        for (int i = 1; i < int'(n); i++) begin
            held = words[i];
            j    = i - 1;
            while (j >= 0 && words[j] > held) begin
                words[j + 1] = words[j];
                j--;
            end
            words[j + 1] = held;
        end
        for (int i = 0; i < int'(n); i++) begin
            send_item(FUNC_WRITE, SLOT_W'(i), words[i]);
        end
    endtask

    // Result side: random stall before each transfer, plus a long hold-off
    // twice while lookups stream in, so the block backs up into o_in_stall.
    initial begin : result_side
        int unsigned     gap;
        t_search_result  got;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = flow_gap();
            if (in_lookup_run && holds_done < 2 &&
                results_done >= ((holds_done == 0) ? 100 : 450)) begin
                gap = HOLD_CYCLES;
                holds_done++;
            end
            if (gap != 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.found    = o_found;
            got.position = o_position;
            search_board.check_result(got);
            results_done++;
            @(negedge i_clk);
        end
    end

    initial begin : stimulus
        int unsigned       count;
        int unsigned       n_eff;
        int unsigned       filled;      // slots 0..filled-1 hold written words
        int unsigned       phase;
        int unsigned       directed_items;
        search_board = new();
        foreach (prefixes[i]) prefixes[i] = HALF_W'({$urandom, $urandom});
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // empty table: count is zero after reset, no entry is compared
        send_item(FUNC_LOOKUP, 7'h55, W_ZERO);
        send_item(FUNC_LOOKUP, 7'h2A, W_ONES);
        send_item(FUNC_WRITE, 7'd0, W_ZERO);
        send_item(FUNC_WRITE, 7'd1, W_GAP_A);
        send_item(FUNC_WRITE, 7'd2, W_GAP_B);
        send_item(FUNC_WRITE, 7'd3, W_ONES);
        settle();
        write_count(COUNT_W'(4));
        in_lookup_run = 1'b1;
        // hits at every position, both field extremes among them
        send_item(FUNC_LOOKUP, 7'h7F, W_ZERO);
        send_item(FUNC_LOOKUP, 7'h00, W_GAP_A);
        send_item(FUNC_LOOKUP, 7'h33, W_GAP_B);
        send_item(FUNC_LOOKUP, 7'h4C, W_ONES);
        // misses: low half decides, bytes after a zero byte, just below max
        send_item(FUNC_LOOKUP, 7'h01, {56'h41004200000000, 56'h00000000000002});
        send_item(FUNC_LOOKUP, 7'h02, {56'h41000000000000, 56'h000000000000FF});
        send_item(FUNC_LOOKUP, 7'h04, {56'h00000000000041, 56'h00000000000000});
        send_item(FUNC_LOOKUP, 7'h08, W_ONES - 1'b1);
        // unsorted table: the all-ones word lands in slot 1, so the search
        // turns away from a word that is present
        send_item(FUNC_WRITE, 7'd1, W_ONES);
        send_item(FUNC_LOOKUP, 7'h10, W_GAP_B);
        filled         = 4;
        directed_items = items_sent;

        // --- random phases ---
        // Each phase: quiet block, new count, maybe a fresh sorted table,
        // rarely a few stray writes, then a stream of lookups.
        phase = 0;
        while (items_sent < directed_items + RANDOM_ITEMS) begin
            settle();
            case (phase)
                0: count = 0;
                1: count = 255;                // saturates to the depth
                2: count = 1;
                3: count = DEPTH;
                4: count = DEPTH + 1;
                default: begin
                    case ($urandom_range(0, 9))
                        0: count = 0;
                        1: count = $urandom_range(DEPTH + 1, 255);
                        2: count = 2;
                        default: count = $urandom_range(1, DEPTH);
                    endcase
                end
            endcase
            write_count(COUNT_W'(count));
            n_eff      = (count > DEPTH) ? DEPTH : count;
            tight_flow = ($urandom_range(0, 3) == 0);
            foreach (prefixes[i]) prefixes[i] = HALF_W'({$urandom, $urandom});
            // never search a slot that was not written
            if (n_eff > filled || $urandom_range(0, 2) == 0) begin
                load_sorted(n_eff);
                if (n_eff > filled) filled = n_eff;
            end
            if ($urandom_range(0, 6) == 0) begin
                repeat ($urandom_range(1, 4)) begin
                    send_item(FUNC_WRITE, SLOT_W'($urandom_range(0, DEPTH - 1)), random_word());
                end
            end
            in_lookup_run = 1'b1;
            repeat ($urandom_range(20, 60)) begin
                send_item(FUNC_LOOKUP, SLOT_W'($urandom), probe_key(n_eff));
            end
            phase++;
        end

        settle();
        if (search_board.pending() != 0) begin
            $error("%0d lookups never answered", search_board.pending());
        end
        if (search_board.mismatches == 0 && search_board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
